// ===== rtl/arss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range sample scaler package
// Shared constants, item kind codes, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package arss_pkg;

  // Field widths that the interface fixes.
  localparam int unsigned KIND_BITS  = 2;
  localparam int unsigned SCALE_BITS = 8;
  localparam int unsigned RANGE_BITS = 12;
  localparam int unsigned TRIM_BITS  = 16;
  localparam int unsigned STEP_BITS  = $clog2(SCALE_BITS);

  // Trim period after reset, in milliseconds.
  localparam logic [TRIM_BITS-1:0] TRIM_RESET = 16'd2500;

  // Item kinds carried on the input tuser.
  localparam logic [KIND_BITS-1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic update;
    logic div_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sample;
  } dp_status_t;

endpackage

// ===== rtl/adaptive_range_sample_scaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range sample scaler
// Scales converter samples to a byte over a range that tracks the signal and
// is periodically trimmed toward the extremes of the latest window.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one item per transaction: tuser carries the kind
//   (sample, millisecond tick, restart) and tdata the sample. Every item
//   yields exactly one transaction on the master stream carrying the scaled
//   byte, the overall maximum and minimum, and in tuser a flag that is set
//   for samples.
//   From acceptance to a loaded result, a sample passes the range update,
//   dividend setup, eight restoring divide steps sharing one subtractor,
//   and the hand-off; ticks, restarts and unused kinds skip the divide.
//   The next item is accepted in the cycle after the hand-off, so no new
//   item enters while one is still being worked on.
//   The result sits in an output register; a new item is accepted and
//   worked on while it waits. When the receiver stalls, the block holds the
//   next finished result until that register drains.
//   The trim period is written over the cfg channel, which is always ready;
//   write it only while no transaction is in flight.
//   Reset clears the tracker, the tick count and both streams, and sets the
//   trim period to 2500 ms.
// ----------------------------------------------------------------------------
module adaptive_range_sample_scaler_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample
  input  logic [arss_pkg::KIND_BITS-1:0]     s_axis_tuser,  // kind
  // Master stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // scaled, range_high, range_low
  output logic                               m_axis_tuser,  // scaled_valid
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [arss_pkg::TRIM_BITS-1:0]     cfg_data_i     // trim_period_ms
);

  arss_pkg::dp_cmd_t    cmd;
  arss_pkg::dp_status_t status;

  logic [arss_pkg::SCALE_BITS-1:0] out_scaled;
  logic                            out_flag;
  logic [arss_pkg::RANGE_BITS-1:0] out_high;
  logic [arss_pkg::RANGE_BITS-1:0] out_low;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  arss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tracker, divider and result register.
  arss_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .item_kind_i   (s_axis_tuser),
    .item_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_scaled_o  (out_scaled),
    .out_flag_o    (out_flag),
    .out_high_o    (out_high),
    .out_low_o     (out_low)
  );

  // Pack the result fields: scaled byte lowest, then range_high, then range_low.
  assign m_axis_tdata = {out_low, out_high, out_scaled};
  assign m_axis_tuser = out_flag;

endmodule

// ===== rtl/arss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range sample scaler datapath
// Holds the captured item, the range tracker, the trim counter, the
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module arss_datapath #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  arss_pkg::dp_cmd_t                  cmd_i,
  output arss_pkg::dp_status_t               status_o,
  input  logic                               cfg_we_i,
  input  logic [arss_pkg::TRIM_BITS-1:0]     cfg_data_i,
  input  logic [arss_pkg::KIND_BITS-1:0]     item_kind_i,
  input  logic [SAMPLE_BITS-1:0]             item_sample_i,
  output logic [arss_pkg::SCALE_BITS-1:0]    out_scaled_o,
  output logic                               out_flag_o,
  output logic [arss_pkg::RANGE_BITS-1:0]    out_high_o,
  output logic [arss_pkg::RANGE_BITS-1:0]    out_low_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned QB = arss_pkg::SCALE_BITS;
  localparam int unsigned TB = arss_pkg::TRIM_BITS;
  localparam logic [SB-1:0] SAMPLE_MAX = '1;

  // Captured item.
  logic [arss_pkg::KIND_BITS-1:0] kind_q;
  logic [SB-1:0]                  sample_q;

  // Configuration and tracker state.
  logic [TB-1:0] trim_period_q;
  logic [SB-1:0] omax_q, omax_d;
  logic [SB-1:0] omin_q, omin_d;
  logic [SB-1:0] wmax_q, wmax_d;
  logic [SB-1:0] wmin_q, wmin_d;
  logic [TB-1:0] ms_q, ms_d;

  // Divider state: remainder and the shifting low byte that becomes the quotient.
  logic          flat_q;
  logic [SB-1:0] rem_q, rem_d;
  logic [QB-1:0] quo_q, quo_d;

  // Result register.
  logic [QB-1:0]                   out_scaled_q;
  logic                            out_flag_q;
  logic [arss_pkg::RANGE_BITS-1:0] out_high_q;
  logic [arss_pkg::RANGE_BITS-1:0] out_low_q;

  logic          is_sample;
  logic [TB-1:0] ms_inc;
  logic [SB:0]   sum_max;
  logic [SB:0]   sum_min;
  logic [SB-1:0] span;
  logic [SB-1:0] offs;
  logic [SB+QB-1:0] prod;
  logic [SB:0]   trial;
  logic [SB:0]   trial_diff;
  logic          trial_ge;

  assign is_sample          = (kind_q == arss_pkg::KIND_SAMPLE);
  assign status_o.is_sample = is_sample;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q   <= item_kind_i;
      sample_q <= item_sample_i;
    end
  end

  // Trim period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_period_q <= arss_pkg::TRIM_RESET;
    end else if (cfg_we_i) begin
      trim_period_q <= cfg_data_i;
    end
  end

  // Next tracker state for the captured item.
  assign ms_inc  = ms_q + 1'b1;
  assign sum_max = {1'b0, omax_q} + {1'b0, wmax_q};
  assign sum_min = {1'b0, omin_q} + {1'b0, wmin_q};

  always_comb begin
    omax_d = omax_q;
    omin_d = omin_q;
    wmax_d = wmax_q;
    wmin_d = wmin_q;
    ms_d   = ms_q;
    unique case (kind_q)
      arss_pkg::KIND_SAMPLE: begin
        if (sample_q > omax_q) omax_d = sample_q;
        if (sample_q < omin_q) omin_d = sample_q;
        if (sample_q > wmax_q) wmax_d = sample_q;
        if (sample_q < wmin_q) wmin_d = sample_q;
      end
      arss_pkg::KIND_TICK: begin
        if (ms_inc >= trim_period_q) begin
          // Pull each overall extreme halfway toward its window extreme.
          if (omax_q != wmax_q) omax_d = sum_max[SB:1];
          if (omin_q != wmin_q) omin_d = sum_min[SB:1];
          wmax_d = '0;
          wmin_d = SAMPLE_MAX;
          ms_d   = '0;
        end else begin
          ms_d = ms_inc;
        end
      end
      arss_pkg::KIND_RESTART: begin
        omax_d = '0;
        omin_d = SAMPLE_MAX;
        wmax_d = '0;
        wmin_d = SAMPLE_MAX;
        ms_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omax_q <= '0;
      omin_q <= SAMPLE_MAX;
      wmax_q <= '0;
      wmin_q <= SAMPLE_MAX;
      ms_q   <= '0;
    end else if (cmd_i.update) begin
      omax_q <= omax_d;
      omin_q <= omin_d;
      wmax_q <= wmax_d;
      wmin_q <= wmin_d;
      ms_q   <= ms_d;
    end
  end

  // Dividend offs * 255 formed as offs * 256 - offs; the quotient fits a byte
  // because the sample lies inside the range after the update.
  assign span = omax_q - omin_q;
  assign offs = sample_q - omin_q;
  assign prod = {offs, {QB{1'b0}}} - {{QB{1'b0}}, offs};

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial      = {rem_q, quo_q[QB-1]};
  assign trial_diff = trial - {1'b0, span};
  assign trial_ge   = (trial >= {1'b0, span});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_init) begin
      rem_d = prod[SB+QB-1:QB];
      quo_d = prod[QB-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = trial_ge ? trial_diff[SB-1:0] : trial[SB-1:0];
      quo_d = {quo_q[QB-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.div_init) begin
      flat_q <= (omax_q <= omin_q);
    end
  end

  // Result register, loaded once the item is finished.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_scaled_q <= (is_sample && !flat_q) ? quo_q : '0;
      out_flag_q   <= is_sample;
      out_high_q   <= arss_pkg::RANGE_BITS'(omax_q);
      out_low_q    <= arss_pkg::RANGE_BITS'(omin_q);
    end
  end

  assign out_scaled_o = out_scaled_q;
  assign out_flag_o   = out_flag_q;
  assign out_high_o   = out_high_q;
  assign out_low_o    = out_low_q;

endmodule

// ===== rtl/arss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range sample scaler controller
// Sequences capture, tracker update, the eight divide steps and the
// hand-off to the result register; owns both stream handshakes.
// ----------------------------------------------------------------------------
module arss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  arss_pkg::dp_status_t status_i,
  output arss_pkg::dp_cmd_t    cmd_o
);

  localparam logic [arss_pkg::STEP_BITS-1:0] STEP_LAST =
    arss_pkg::STEP_BITS'(arss_pkg::SCALE_BITS - 1);

  arss_pkg::ctrl_state_e state_q, state_d;
  logic [arss_pkg::STEP_BITS-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arss_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      arss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = arss_pkg::ST_UPDATE;
        end
      end
      arss_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = status_i.is_sample ? arss_pkg::ST_PREP : arss_pkg::ST_DONE;
      end
      arss_pkg::ST_PREP: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = arss_pkg::ST_DIVIDE;
      end
      arss_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = arss_pkg::ST_DONE;
        end
      end
      arss_pkg::ST_DONE: begin
        // Hand over once the result register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = arss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arss_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/sv/tb_adaptive_range_sample_scaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range sample scaler testbench
// Streams samples, millisecond ticks, restarts and unused kinds into the
// scaler with bursty input and a stalling receiver. Each accepted item runs
// through a tracker model kept in step with the block. The trim period is
// reprogrammed between phases while the block is idle. Every output
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_adaptive_range_sample_scaler_unit;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned DATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned SCALE_TOP     = 255;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 125;

  // The one kind code that the block leaves unused.
  localparam logic [arss_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_e;

  typedef struct packed {
    logic [arss_pkg::KIND_BITS-1:0] kind;
    logic [DATA_BITS-1:0]           data;
  } stream_item_t;

  typedef struct packed {
    logic [arss_pkg::SCALE_BITS-1:0] scaled;
    logic                            scaled_valid;
    logic [arss_pkg::RANGE_BITS-1:0] range_high;
    logic [arss_pkg::RANGE_BITS-1:0] range_low;
  } scaler_result_t;

  // Block ports.
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [DATA_BITS-1:0]           s_axis_tdata  = '0;  // sample
  logic [arss_pkg::KIND_BITS-1:0] s_axis_tuser  = '0;  // kind
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;        // scaled, range_high, range_low
  logic                           m_axis_tuser;        // scaled_valid
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [arss_pkg::TRIM_BITS-1:0] cfg_data_i    = '0;  // trim_period_ms

  // Stimulus and prediction stores.
  stream_item_t   sample_stream[$];
  scaler_result_t predicted_outputs[$];
  stream_item_t   next_item;
  scaler_result_t seen_output;
  scaler_result_t oldest_prediction;
  int unsigned    burst_left   = 1;
  int unsigned    gap_left     = 0;
  int unsigned    mode_left    = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    error_count  = 0;
  logic [7:0]     rx_cycle     = '0;
  rx_pattern_e    rx_pattern   = RX_ALWAYS;

  // Tracker copy kept by the testbench.
  logic [arss_pkg::RANGE_BITS-1:0] track_max   = '0;
  logic [arss_pkg::RANGE_BITS-1:0] track_min   = arss_pkg::RANGE_BITS'(SAMPLE_TOP);
  logic [arss_pkg::RANGE_BITS-1:0] win_max     = '0;
  logic [arss_pkg::RANGE_BITS-1:0] win_min     = arss_pkg::RANGE_BITS'(SAMPLE_TOP);
  logic [arss_pkg::TRIM_BITS-1:0]  ms_count    = '0;
  logic [arss_pkg::TRIM_BITS-1:0]  trim_period = arss_pkg::TRIM_RESET;

  adaptive_range_sample_scaler_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_tracker();
    track_max = '0;
    track_min = arss_pkg::RANGE_BITS'(SAMPLE_TOP);
    win_max   = '0;
    win_min   = arss_pkg::RANGE_BITS'(SAMPLE_TOP);
    ms_count  = '0;
  endfunction

  // At the end of a trim period each overall extreme moves halfway toward
  // the window extreme, and the window starts over.
  function automatic void pull_range_to_window();
    int unsigned sum;
    if (track_max != win_max) begin
      sum       = track_max + win_max;
      track_max = arss_pkg::RANGE_BITS'(sum >> 1);
    end
    if (track_min != win_min) begin
      sum       = track_min + win_min;
      track_min = arss_pkg::RANGE_BITS'(sum >> 1);
    end
    win_max = '0;
    win_min = arss_pkg::RANGE_BITS'(SAMPLE_TOP);
  endfunction

  // Advances the tracker by one item and returns the result it yields.
  function automatic scaler_result_t track_and_scale(stream_item_t item);
    scaler_result_t                  res;
    logic [arss_pkg::RANGE_BITS-1:0] smp;
    int unsigned                     offs;
    int unsigned                     span;
    int unsigned                     quo;
    res = '0;
    smp = item.data[SAMPLE_BITS-1:0];
    case (item.kind)
      arss_pkg::KIND_SAMPLE: begin
        if (smp > track_max) track_max = smp;
        if (smp < track_min) track_min = smp;
        if (smp > win_max) win_max = smp;
        if (smp < win_min) win_min = smp;
        res.scaled_valid = 1'b1;
        // A flat or inverted range scales to zero.
        if (track_max > track_min) begin
          span       = track_max - track_min;
          offs       = (smp >= track_min) ? smp - track_min : 0;
          quo        = offs * SCALE_TOP / span;
          res.scaled = arss_pkg::SCALE_BITS'((quo > SCALE_TOP) ? SCALE_TOP : quo);
        end
      end
      arss_pkg::KIND_TICK: begin
        ms_count = ms_count + 1'b1;
        if (ms_count >= trim_period) begin
          pull_range_to_window();
          ms_count = '0;
        end
      end
      arss_pkg::KIND_RESTART: begin
        clear_tracker();
      end
      default: begin
      end
    endcase
    res.range_high = track_max;
    res.range_low  = track_min;
    return res;
  endfunction

  task automatic check_field(string what, logic [arss_pkg::RANGE_BITS-1:0] want,
                             logic [arss_pkg::RANGE_BITS-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_stream.size() != 0) begin
        next_item     = sample_stream.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_item.data;
        s_axis_tuser  <= next_item.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns at random intervals.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (mode_left == 0) begin
        rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_pattern)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= (rx_cycle[2:0] == 3'd0);
        default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: checks results, predicts accepted items and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_output.scaled       = m_axis_tdata[arss_pkg::SCALE_BITS-1:0];
        seen_output.scaled_valid = m_axis_tuser;
        seen_output.range_high   =
          m_axis_tdata[arss_pkg::SCALE_BITS +: arss_pkg::RANGE_BITS];
        seen_output.range_low    =
          m_axis_tdata[arss_pkg::SCALE_BITS+arss_pkg::RANGE_BITS +: arss_pkg::RANGE_BITS];
        if (predicted_outputs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   seen_output);
        end else begin
          oldest_prediction = predicted_outputs.pop_front();
          check_field("scaled", oldest_prediction.scaled, seen_output.scaled);
          check_field("scaled_valid", oldest_prediction.scaled_valid,
                      seen_output.scaled_valid);
          check_field("range_high", oldest_prediction.range_high, seen_output.range_high);
          check_field("range_low", oldest_prediction.range_low, seen_output.range_low);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_outputs.push_back(track_and_scale('{kind: s_axis_tuser,
                                                      data: s_axis_tdata}));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_item(logic [arss_pkg::KIND_BITS-1:0] kind,
                            logic [DATA_BITS-1:0] data);
    sample_stream.push_back('{kind: kind, data: data});
  endtask

  // Waits until every item has gone through and every result has come back.
  task automatic wait_until_drained();
    while (sample_stream.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_trim_period(logic [arss_pkg::TRIM_BITS-1:0] value);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    trim_period = value;
  endtask

  // Random traffic: mostly samples clustered around a wandering center,
  // with ticks, the odd restart and the unused kind mixed in.
  task automatic queue_random_items(int unsigned count);
    int unsigned  center;
    int unsigned  spread;
    int unsigned  roll;
    int unsigned  lo;
    int unsigned  hi;
    stream_item_t item;
    center = $urandom_range(0, SAMPLE_TOP);
    spread = $urandom_range(0, 300);
    repeat (count) begin
      roll      = $urandom_range(0, 99);
      item.data = DATA_BITS'($urandom_range(0, (1 << DATA_BITS) - 1));
      if (roll < 70) begin
        item.kind = arss_pkg::KIND_SAMPLE;
        roll      = $urandom_range(0, 99);
        if (roll < 4) begin
          item.data[SAMPLE_BITS-1:0] = (roll < 2) ? '0 : SAMPLE_BITS'(SAMPLE_TOP);
        end else if (roll < 75) begin
          lo = (center > spread) ? center - spread : 0;
          hi = (center + spread > SAMPLE_TOP) ? SAMPLE_TOP : center + spread;
          item.data[SAMPLE_BITS-1:0] = SAMPLE_BITS'($urandom_range(lo, hi));
        end
        // Bits above the sample are usually clear but sometimes set.
        if ($urandom_range(0, 3) != 0) item.data[DATA_BITS-1:SAMPLE_BITS] = '0;
      end else if (roll < 93) begin
        item.kind = arss_pkg::KIND_TICK;
      end else if (roll < 97) begin
        item.kind = arss_pkg::KIND_RESTART;
      end else begin
        item.kind = KIND_UNUSED;
      end
      if ($urandom_range(0, 49) == 0) begin
        center = $urandom_range(0, SAMPLE_TOP);
        spread = $urandom_range(0, 300);
      end
      sample_stream.push_back(item);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset period: extremes, masking of the upper data bits, flat range.
    queue_item(KIND_UNUSED, 16'hFFFF);
    queue_item(arss_pkg::KIND_TICK, 16'h0000);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h0000);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h0FFF);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h0800);
    queue_item(arss_pkg::KIND_SAMPLE, 16'hF800);
    queue_item(arss_pkg::KIND_SAMPLE, 16'hAFFF);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h0001);
    queue_item(arss_pkg::KIND_RESTART, 16'hFFFF);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h04D2);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h04D2);
    queue_item(arss_pkg::KIND_SAMPLE, 16'h04D3);
    queue_item(KIND_UNUSED, 16'h0000);

    // Zero period: every tick trims; an empty window inverts the range
    // until the next sample.
    program_trim_period('0);
    queue_item(arss_pkg::KIND_SAMPLE, 16'd100);
    queue_item(arss_pkg::KIND_SAMPLE, 16'd3000);
    queue_item(arss_pkg::KIND_TICK, 16'h5555);
    queue_item(arss_pkg::KIND_TICK, 16'hAAAA);
    queue_item(KIND_UNUSED, 16'h1234);
    queue_item(arss_pkg::KIND_SAMPLE, 16'd1800);
    queue_item(arss_pkg::KIND_TICK, 16'h0000);
    queue_item(arss_pkg::KIND_SAMPLE, 16'd2600);
    queue_item(arss_pkg::KIND_RESTART, 16'h0000);

    // Random phases, each under its own trim period.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       program_trim_period(16'd1);
        1:       program_trim_period(16'hFFFF);
        2:       program_trim_period('0);
        3:       program_trim_period(arss_pkg::TRIM_RESET);
        4:       program_trim_period(arss_pkg::TRIM_BITS'($urandom_range(0, 65535)));
        default: program_trim_period(arss_pkg::TRIM_BITS'($urandom_range(2, 30)));
      endcase
      queue_random_items(PHASE_ITEMS);
    end

    wait_until_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
